[hdl/gha_pkg.sv]
// Shared types, constants and helper functions of the generational handle allocator.
package gha_pkg;

    localparam int INDEX_BITS = 12;
    localparam int GEN_BITS   = 20;
    localparam int CNT_BITS   = INDEX_BITS + 1;
    localparam int SLOT_COUNT = 1 << INDEX_BITS;

    localparam int HANDLE_W = 32;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int LIVE_W   = 13;
    localparam int CHANGE_W = 32;

    localparam logic [OP_W-1:0] OP_CREATE  = 2'd0;
    localparam logic [OP_W-1:0] OP_DESTROY = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_STALE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    localparam logic [CNT_BITS-1:0] SLOTS_ALL = {1'b1, {INDEX_BITS{1'b0}}};

    typedef logic [INDEX_BITS-1:0] index_t;
    typedef logic [GEN_BITS-1:0]   gen_t;
    typedef logic [CNT_BITS-1:0]   count_t;

    // One entry of the slot memory.
    typedef struct packed {
        logic live;
        gen_t gen;
    } slot_entry_t;

    // One entry of the free stack: the slot and the generation it will reopen with.
    typedef struct packed {
        gen_t   gen;
        index_t idx;
    } stack_entry_t;

    // Result item, last field in the lowest bits.
    typedef struct packed {
        logic [CHANGE_W-1:0] change_count;
        logic [LIVE_W-1:0]   live_total;
        logic                is_alive;
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] handle_out;
    } out_item_t;

    localparam int OUT_BITS   = $bits(out_item_t);
    localparam int M_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;
    localparam int S_TDATA_W  = HANDLE_W;

    // Controller to datapath commands.
    typedef struct packed {
        logic capture;   // latch the input item and launch the memory reads
        logic execute;   // finish the operation and load the output register
    } dp_cmd_t;

    // Generation above index, cut to the handle width.
    function automatic logic [HANDLE_W-1:0] make_handle(index_t idx, gen_t gen);
        logic [63:0] wide;
        wide = 64'({gen, idx});
        return wide[HANDLE_W-1:0];
    endfunction

endpackage

[hdl/gha_ram.sv]
// Generic single-write, single-read memory with registered read data.
module gha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hdl/gha_ctrl.sv]
// Controller: two-state sequencer and the output valid flag.
module gha_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    output gha_pkg::dp_cmd_t cmd
);
    import gha_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic fire;

    assign s_tready = (state_reg == ST_IDLE);
    // The output register is free when empty or being drained this cycle.
    assign fire     = (state_reg == ST_EXEC) && (!out_valid_reg || m_tready);

    assign cmd.capture = s_tvalid && s_tready;
    assign cmd.execute = fire;
    assign m_tvalid    = out_valid_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.capture) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (fire) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[hdl/gha_dp.sv]
// Datapath: slot and free-stack memories, counters, liveness check and result register.
module gha_dp (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  gha_pkg::dp_cmd_t           cmd,
    input  logic [gha_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [gha_pkg::OP_W-1:0]   s_tuser,
    output logic [gha_pkg::M_TDATA_W-1:0] m_tdata
);
    import gha_pkg::*;

    logic [OP_W-1:0]     op_reg;
    logic [HANDLE_W-1:0] handle_reg;
    count_t              free_depth_reg, free_depth_next;
    count_t              slots_used_reg, slots_used_next;
    count_t              live_count_reg, live_count_next;
    logic [CHANGE_W-1:0] version_reg, version_next;
    out_item_t           out_reg, out_next;

    slot_entry_t  slot_rd, slot_wr;
    stack_entry_t stack_rd, stack_wr;
    logic         slot_we, stack_we;
    index_t       slot_waddr, stack_waddr, stack_raddr;
    count_t       depth_less;

    index_t h_idx;
    gen_t   gen_raised;
    logic   h_live;
    index_t new_idx;
    gen_t   new_gen;

    // The pop address is the top of the stack; unused when the stack is empty.
    assign depth_less  = free_depth_reg - count_t'(1);
    assign stack_raddr = depth_less[INDEX_BITS-1:0];

    gha_ram #(.WIDTH($bits(slot_entry_t)), .DEPTH(SLOT_COUNT)) u_slot_ram (
        .clk   (aclk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wr),
        .re    (cmd.capture),
        .raddr (s_tdata[INDEX_BITS-1:0]),
        .rdata (slot_rd)
    );

    gha_ram #(.WIDTH($bits(stack_entry_t)), .DEPTH(SLOT_COUNT)) u_stack_ram (
        .clk   (aclk),
        .we    (stack_we),
        .waddr (stack_waddr),
        .wdata (stack_wr),
        .re    (cmd.capture),
        .raddr (stack_raddr),
        .rdata (stack_rd)
    );

    // Slots at or above the issue mark were never written, and slot zero never is,
    // so both read as not live without clearing the memory.
    assign h_idx  = handle_reg[INDEX_BITS-1:0];
    assign h_live = (handle_reg != '0) && (h_idx != '0)
                 && ({1'b0, h_idx} < slots_used_reg) && slot_rd.live
                 && (make_handle(h_idx, slot_rd.gen) == handle_reg);

    always_comb begin
        gen_raised = slot_rd.gen + gen_t'(1);
        if (gen_raised == '0) begin
            gen_raised = gen_t'(1);
        end
    end

    always_comb begin
        free_depth_next = free_depth_reg;
        slots_used_next = slots_used_reg;
        live_count_next = live_count_reg;
        version_next    = version_reg;
        slot_we         = 1'b0;
        stack_we        = 1'b0;
        slot_waddr      = h_idx;
        slot_wr         = '{live: 1'b0, gen: gen_raised};
        stack_waddr     = free_depth_reg[INDEX_BITS-1:0];
        stack_wr        = '{gen: gen_raised, idx: h_idx};
        new_idx         = stack_rd.idx;
        new_gen         = (stack_rd.gen == '0) ? gen_t'(1) : stack_rd.gen;
        out_next.handle_out   = handle_reg;
        out_next.status       = ST_OK;
        out_next.is_alive     = 1'b0;

        unique case (op_reg)
            OP_CREATE: begin
                if (free_depth_reg != '0) begin
                    free_depth_next = depth_less;
                end else if (slots_used_reg != SLOTS_ALL) begin
                    new_idx         = slots_used_reg[INDEX_BITS-1:0];
                    new_gen         = gen_t'(1);
                    slots_used_next = slots_used_reg + count_t'(1);
                end
                if (free_depth_reg != '0 || slots_used_reg != SLOTS_ALL) begin
                    slot_we         = 1'b1;
                    slot_waddr      = new_idx;
                    slot_wr         = '{live: 1'b1, gen: new_gen};
                    live_count_next = live_count_reg + count_t'(1);
                    version_next    = version_reg + CHANGE_W'(1);
                    out_next.handle_out = make_handle(new_idx, new_gen);
                    out_next.is_alive   = 1'b1;
                end else begin
                    out_next.handle_out = '0;
                    out_next.status     = ST_FULL;
                end
            end
            OP_DESTROY: begin
                if (h_live) begin
                    slot_we = 1'b1;
                    if (free_depth_reg != SLOTS_ALL) begin
                        stack_we        = 1'b1;
                        free_depth_next = free_depth_reg + count_t'(1);
                    end
                    if (live_count_reg != '0) begin
                        live_count_next = live_count_reg - count_t'(1);
                    end
                    version_next = version_reg + CHANGE_W'(1);
                end else begin
                    out_next.status = ST_STALE;
                end
            end
            default: begin
                // Query, and the unused code handled the same way.
                out_next.is_alive = h_live;
                out_next.status   = h_live ? ST_OK : ST_STALE;
            end
        endcase

        out_next.live_total   = LIVE_W'(live_count_next);
        out_next.change_count = version_next;

        if (!cmd.execute) begin
            slot_we         = 1'b0;
            stack_we        = 1'b0;
            free_depth_next = free_depth_reg;
            slots_used_next = slots_used_reg;
            live_count_next = live_count_reg;
            version_next    = version_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_depth_reg <= '0;
            slots_used_reg <= count_t'(1);
            live_count_reg <= '0;
            version_reg    <= '0;
        end else begin
            free_depth_reg <= free_depth_next;
            slots_used_reg <= slots_used_next;
            live_count_reg <= live_count_next;
            version_reg    <= version_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg     <= s_tuser;
            handle_reg <= s_tdata[HANDLE_W-1:0];
        end
        if (cmd.execute) begin
            out_reg <= out_next;
        end
    end

    assign m_tdata = M_TDATA_W'(out_reg);

endmodule

[hdl/generational_handle_allocator.sv]
// Top level of the generational handle allocator: controller plus datapath.
//
//  Channel  | Direction | Payload                                    | Handshake
//  ---------+-----------+--------------------------------------------+------------------
//  s_       | in        | tuser: opcode; tdata: handle_in            | s_tvalid/s_tready
//  m_       | out       | tdata: handle_out, status, is_alive,       | m_tvalid/m_tready
//           |           |        live_total, change_count            |
//
// In the accept cycle of an item the slot memory and the free stack are read; in the
// execute state, once the output register is free, the check is made, both memories
// are written and the result is loaded into the output register. Because of this single
// read-modify-write of these memories, a new item is accepted only once the last is done.
// Reset is synchronous and active low; it clears the counters and the control state.
// Liveness of unissued slots comes from the issue mark, so no clearing pass is run and
// the block takes items from the first cycle after reset.
// A result that waits in the output register does not block acceptance; only the
// finishing cycle of the next item waits until the register has been taken.
module generational_handle_allocator (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata: handle_in [31:0]
    input  logic [gha_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: opcode [1:0]
    input  logic [gha_pkg::OP_W-1:0]      s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata: handle_out [31:0], status [33:32], is_alive [34],
    //          live_total [47:35], change_count [79:48]
    output logic [gha_pkg::M_TDATA_W-1:0] m_tdata
);
    import gha_pkg::*;

    dp_cmd_t cmd;

    // The controller only sequences; all state of the allocation lives in the datapath.
    gha_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    gha_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tdata  (m_tdata)
    );

endmodule

[hdl/gha_checker.sv]
// Port-level checks of the generational handle allocator, bound to the top level.
module gha_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [gha_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [gha_pkg::OP_W-1:0]      s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [gha_pkg::M_TDATA_W-1:0] m_tdata
);
    import gha_pkg::*;

    out_item_t item;
    assign item = out_item_t'(m_tdata[OUT_BITS-1:0]);

    // A held result must not change under back-pressure.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // An accept drops s_tready, so items are never taken back to back.
    a_spacing: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted in adjacent cycles");

    // A full create carries the null handle and no liveness.
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (item.status == ST_FULL) |-> (item.handle_out == '0) && !item.is_alive)
        else $error("full result with a handle");

    // Liveness is only reported together with success.
    a_alive_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && item.is_alive |-> (item.status == ST_OK) && (item.handle_out != '0))
        else $error("live result without success");

    // Slot zero is never issued, so the live count stays below the slot count.
    a_live_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (32'(item.live_total) < 32'(SLOT_COUNT)))
        else $error("live count out of range");

endmodule

bind generational_handle_allocator gha_checker u_gha_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
